### rtl/sfp_pkg.sv
// sfp_pkg: shared types and constants for the spherical point flipping block
// used by sfp_step and spherical_flip_points; no dependencies

package sfp_pkg;

    localparam int unsigned COORD_BITS_DEF = 16;

    typedef enum logic [1:0] {
        FUNC_MEASURE = 2'd0,
        FUNC_FLIP    = 2'd1,
        FUNC_CLEAR   = 2'd2
    } t_func;

    typedef enum logic {
        STEP_SQRT = 1'b0,
        STEP_DIV  = 1'b1
    } t_step_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_MAX,
        ST_RAD,
        ST_NORM,
        ST_PREP,
        ST_MUL,
        ST_DLOAD,
        ST_DIV,
        ST_WB,
        ST_OUT
    } t_state;

endpackage

### rtl/sfp_step.sv
// sfp_step: one shared compare-subtract step, serving both the digit-by-digit
// square root (two radicand bits a step) and restoring division (one bit a step)
// depends on sfp_pkg

module sfp_step #(
    parameter int unsigned COORD_BITS = sfp_pkg::COORD_BITS_DEF,
    localparam int unsigned UW = COORD_BITS + 4,
    localparam int unsigned AW = COORD_BITS + 2
) (
    input  sfp_pkg::t_step_mode   i_mode,
    input  logic [UW-1:0]         i_rem,
    input  logic [AW-1:0]         i_acc,
    input  logic [1:0]            i_bits,
    input  logic [COORD_BITS-1:0] i_div,
    output logic [UW-1:0]         o_rem,
    output logic [AW-1:0]         o_acc
);

    logic [UW-1:0] sh;
    logic [UW-1:0] trial;
    logic [UW-1:0] diff;
    logic          ge;

    always_comb begin
        case (i_mode)
            sfp_pkg::STEP_SQRT: begin
                sh    = {i_rem[UW-3:0], i_bits};
                trial = {2'b00, i_acc[COORD_BITS-1:0], 2'b01};
            end
            sfp_pkg::STEP_DIV: begin
                sh    = {i_rem[UW-2:0], i_bits[1]};
                trial = {4'b0000, i_div};
            end
            default: begin
                sh    = {i_rem[UW-3:0], i_bits};
                trial = {2'b00, i_acc[COORD_BITS-1:0], 2'b01};
            end
        endcase
        diff  = sh - trial;
        ge    = (sh >= trial);
        o_rem = ge ? diff : sh;
        o_acc = {i_acc[AW-2:0], ge};
    end

endmodule

### rtl/spherical_flip_points.sv
// spherical_flip_points: spherical flipping of viewer-space points, one beat at a time
// measure: busy for three squares on the shared multiplier, then the max update
// flip: squares, a radius square root when none is held, the norm square root, then per axis a
// multiply, divide and write-back (skipped at the origin); the shared sqrt/divide step does a digit a cycle
// clear: handled in idle without going busy; the next beat is taken as soon as the block is in idle
// synchronous active-low reset clears the stored maximum, radius, radius flag, state and output valid

module spherical_flip_points #(
    parameter int unsigned COORD_BITS = sfp_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_func,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS+1:0] o_out_x,
    output logic signed [COORD_BITS+1:0] o_out_y,
    output logic signed [COORD_BITS+1:0] o_out_z,
    output logic                         o_at_origin
);

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned OB = C + 2;
    localparam int unsigned QB = OB;
    localparam int unsigned NW = 2 * C + 1;
    localparam int unsigned UW = C + 4;
    localparam int unsigned AW = C + 2;
    localparam int unsigned CW = $clog2(C + 2);

    sfp_pkg::t_state r_state, n_state;

    logic [2*C-1:0] r_max, n_max;
    logic [C-1:0]   r_radius, n_radius;
    logic           r_rvalid, n_rvalid;
    logic           r_flip, n_flip;
    logic [C-1:0]   r_mag [3];
    logic [C-1:0]   n_mag [3];
    logic [2:0]     r_sign, n_sign;
    logic [1:0]     r_idx, n_idx;
    logic [2*C-1:0] r_dsq, n_dsq;
    logic [2*C-1:0] r_src, n_src;
    logic [UW-1:0]  r_rem, n_rem;
    logic [AW-1:0]  r_acc, n_acc;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [C-1:0]   r_nrm, n_nrm;
    logic [C:0]     r_m, n_m;
    logic           r_fneg, n_fneg;
    logic [NW-1:0]  r_num, n_num;
    logic           r_sat, n_sat;
    logic [OB-1:0]  r_res [3];
    logic [OB-1:0]  n_res [3];
    logic           r_origin, n_origin;

    logic          r_out_valid, n_out_valid;
    logic [OB-1:0] r_out_x, r_out_y, r_out_z;
    logic          r_out_org;
    logic          out_load;

    logic          in_acc;
    logic [C-1:0]  mul_a;
    logic [C:0]    mul_b;
    logic [NW-1:0] prod;

    sfp_pkg::t_step_mode step_mode;
    logic [UW-1:0]       step_rem;
    logic [AW-1:0]       step_acc;

    logic          sqrt_done;
    logic          div_done;
    logic [C:0]    two_r;
    logic [C:0]    nrm_ext;
    logic          wb_neg;
    logic [OB-1:0] wb_lim;
    logic [OB-1:0] wb_mag;

    assign o_stall = (r_state != sfp_pkg::ST_IDLE);
    assign in_acc  = i_valid && !o_stall;

    // shared multiplier: squares at the start of both functions, p*m while flipping
    assign mul_a = r_mag[r_idx];
    assign mul_b = (r_state == sfp_pkg::ST_SQ) ? {1'b0, r_mag[r_idx]} : r_m;
    assign prod  = NW'(mul_a) * NW'(mul_b);

    assign step_mode = (r_state == sfp_pkg::ST_DIV) ? sfp_pkg::STEP_DIV : sfp_pkg::STEP_SQRT;

    sfp_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_mode (step_mode),
        .i_rem  (r_rem),
        .i_acc  (r_acc),
        .i_bits (r_src[2*C-1:2*C-2]),
        .i_div  (r_nrm),
        .o_rem  (step_rem),
        .o_acc  (step_acc)
    );

    assign sqrt_done = (r_cnt == CW'(C - 1));
    assign div_done  = (r_cnt == CW'(QB - 1));
    assign two_r     = {r_radius, 1'b0};
    assign nrm_ext   = {1'b0, r_nrm};
    assign out_load  = (r_state == sfp_pkg::ST_OUT) && (!r_out_valid || !i_stall);

    always_comb begin
        wb_neg = r_sign[r_idx] ^ r_fneg;
        wb_lim = wb_neg ? {1'b1, {(OB-1){1'b0}}} : {1'b0, {(OB-1){1'b1}}};
        wb_mag = (r_sat || (r_acc > wb_lim)) ? wb_lim : r_acc;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfp_pkg::ST_IDLE: begin
                if (in_acc && (i_func == sfp_pkg::FUNC_MEASURE || i_func == sfp_pkg::FUNC_FLIP)) begin
                    n_state = sfp_pkg::ST_SQ;
                end
            end
            sfp_pkg::ST_SQ: begin
                if (r_idx == 2'd2) begin
                    if (!r_flip) begin
                        n_state = sfp_pkg::ST_MAX;
                    end else if (!r_rvalid) begin
                        n_state = sfp_pkg::ST_RAD;
                    end else begin
                        n_state = sfp_pkg::ST_NORM;
                    end
                end
            end
            sfp_pkg::ST_MAX: n_state = sfp_pkg::ST_IDLE;
            sfp_pkg::ST_RAD: begin
                if (sqrt_done) begin
                    n_state = sfp_pkg::ST_NORM;
                end
            end
            sfp_pkg::ST_NORM: begin
                if (sqrt_done) begin
                    n_state = sfp_pkg::ST_PREP;
                end
            end
            sfp_pkg::ST_PREP: begin
                n_state = (r_nrm == '0) ? sfp_pkg::ST_OUT : sfp_pkg::ST_MUL;
            end
            sfp_pkg::ST_MUL:   n_state = sfp_pkg::ST_DLOAD;
            sfp_pkg::ST_DLOAD: n_state = sfp_pkg::ST_DIV;
            sfp_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = sfp_pkg::ST_WB;
                end
            end
            sfp_pkg::ST_WB: begin
                n_state = (r_idx == 2'd2) ? sfp_pkg::ST_OUT : sfp_pkg::ST_MUL;
            end
            sfp_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = sfp_pkg::ST_IDLE;
                end
            end
            default: n_state = sfp_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_max    = r_max;
        n_radius = r_radius;
        n_rvalid = r_rvalid;
        n_flip   = r_flip;
        n_mag    = r_mag;
        n_sign   = r_sign;
        n_idx    = r_idx;
        n_dsq    = r_dsq;
        n_src    = r_src;
        n_rem    = r_rem;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_nrm    = r_nrm;
        n_m      = r_m;
        n_fneg   = r_fneg;
        n_num    = r_num;
        n_sat    = r_sat;
        n_res    = r_res;
        n_origin = r_origin;

        case (r_state)
            sfp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (sfp_pkg::t_func'(i_func))
                        sfp_pkg::FUNC_MEASURE, sfp_pkg::FUNC_FLIP: begin
                            n_flip   = (i_func == sfp_pkg::FUNC_FLIP);
                            n_sign   = {i_pos_z[C-1], i_pos_y[C-1], i_pos_x[C-1]};
                            n_mag[0] = i_pos_x[C-1] ? (~i_pos_x + C'(1)) : i_pos_x;
                            n_mag[1] = i_pos_y[C-1] ? (~i_pos_y + C'(1)) : i_pos_y;
                            n_mag[2] = i_pos_z[C-1] ? (~i_pos_z + C'(1)) : i_pos_z;
                            n_idx    = 2'd0;
                        end
                        sfp_pkg::FUNC_CLEAR: begin
                            n_max    = '0;
                            n_rvalid = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sfp_pkg::ST_SQ: begin
                n_dsq = ((r_idx == 2'd0) ? '0 : r_dsq) + prod[2*C-1:0];
                n_rem = '0;
                n_acc = '0;
                n_cnt = '0;
                if (r_idx == 2'd2) begin
                    n_idx = 2'd0;
                    n_src = r_rvalid ? n_dsq : r_max;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            sfp_pkg::ST_MAX: begin
                if (r_dsq > r_max) begin
                    n_max = r_dsq;
                end
                n_rvalid = 1'b0;
            end
            sfp_pkg::ST_RAD, sfp_pkg::ST_NORM: begin
                n_rem = step_rem;
                n_acc = step_acc;
                n_src = r_src << 2;
                n_cnt = r_cnt + CW'(1);
                if (sqrt_done) begin
                    n_rem = '0;
                    n_acc = '0;
                    n_cnt = '0;
                    if (r_state == sfp_pkg::ST_RAD) begin
                        n_radius = step_acc[C-1:0];
                        n_rvalid = 1'b1;
                        n_src    = r_dsq;
                    end else begin
                        n_nrm = step_acc[C-1:0];
                    end
                end
            end
            sfp_pkg::ST_PREP: begin
                n_idx    = 2'd0;
                n_origin = (r_nrm == '0);
                if (two_r >= nrm_ext) begin
                    n_m    = two_r - nrm_ext;
                    n_fneg = 1'b0;
                end else begin
                    n_m    = nrm_ext - two_r;
                    n_fneg = 1'b1;
                end
                if (r_nrm == '0) begin
                    n_res[0] = '0;
                    n_res[1] = '0;
                    n_res[2] = '0;
                end
            end
            sfp_pkg::ST_MUL: begin
                // add half the norm so the quotient comes out rounded
                n_num = prod + {{(NW-C){1'b0}}, 1'b0, r_nrm[C-1:1]};
            end
            sfp_pkg::ST_DLOAD: begin
                // quotient would not fit the result width
                n_sat = ({1'b0, r_num[NW-1:QB]} >= r_nrm);
                n_rem = {{(UW-(NW-QB)){1'b0}}, r_num[NW-1:QB]};
                n_src = {r_num[QB-1:0], {(2*C-QB){1'b0}}};
                n_acc = '0;
                n_cnt = '0;
            end
            sfp_pkg::ST_DIV: begin
                n_rem = step_rem;
                n_acc = step_acc;
                n_src = r_src << 1;
                n_cnt = r_cnt + CW'(1);
            end
            sfp_pkg::ST_WB: begin
                n_res[r_idx] = wb_neg ? (~wb_mag + OB'(1)) : wb_mag;
                if (r_idx != 2'd2) begin
                    n_idx = r_idx + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfp_pkg::ST_IDLE;
            r_max       <= '0;
            r_radius    <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_max       <= n_max;
            r_radius    <= n_radius;
            r_rvalid    <= n_rvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flip   <= n_flip;
        r_mag    <= n_mag;
        r_sign   <= n_sign;
        r_idx    <= n_idx;
        r_dsq    <= n_dsq;
        r_src    <= n_src;
        r_rem    <= n_rem;
        r_acc    <= n_acc;
        r_cnt    <= n_cnt;
        r_nrm    <= n_nrm;
        r_m      <= n_m;
        r_fneg   <= n_fneg;
        r_num    <= n_num;
        r_sat    <= n_sat;
        r_res    <= n_res;
        r_origin <= n_origin;
        if (out_load) begin
            r_out_x   <= r_res[0];
            r_out_y   <= r_res[1];
            r_out_z   <= r_res[2];
            r_out_org <= r_origin;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;
    assign o_at_origin = r_out_org;

    // a new result beat only ever comes from the output hand-off state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == sfp_pkg::ST_OUT)
        else $error("result beat raised outside the output state");

    // the point norm is only taken once a radius is held
    a_norm_has_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sfp_pkg::ST_NORM |-> r_rvalid)
        else $error("norm square root running without a radius");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sfp_pkg::ST_DIV |-> r_cnt < CW'(QB))
        else $error("division step count overran");

    a_coord_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfp_pkg::ST_MUL || r_state == sfp_pkg::ST_WB) |-> r_idx != 2'd3)
        else $error("coordinate index out of range");

    // the stored maximum only drops on a clear beat
    a_max_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max < $past(r_max) |-> $past(in_acc && i_func == sfp_pkg::FUNC_CLEAR))
        else $error("stored maximum fell without a clear");

endmodule
